/* src/sps_pkg.sv */
package sps_pkg;

	localparam int PhaseW       = 3;
	localparam int PhaseCount   = 8;
	localparam int CoilW        = 4;
	localparam int NumMotorsDef = 2;

	typedef enum logic [1:0] {
		OP_RIGHT = 2'd0,
		OP_LEFT  = 2'd1,
		OP_OFF   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		MODE_HALF     = 2'd0,
		MODE_FULL_TWO = 2'd1,
		MODE_FULL_ONE = 2'd2
	} mode_t;

	typedef logic [PhaseW-1:0] phase_t;
	typedef logic [CoilW-1:0]  coil_t;

	localparam coil_t CoilTable [PhaseCount] = '{
		coil_t'(1 << 0),
		coil_t'((1 << 0) | (1 << 2)),
		coil_t'(1 << 2),
		coil_t'((1 << 1) | (1 << 2)),
		coil_t'(1 << 1),
		coil_t'((1 << 1) | (1 << 3)),
		coil_t'(1 << 3),
		coil_t'((1 << 0) | (1 << 3))
	};

	function automatic coil_t coil_of(input phase_t ph);
		return CoilTable[ph];
	endfunction

endpackage

/* src/sps_ram.sv */
module sps_ram #(
	parameter int Width = 3,
	parameter int Depth = 2,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/sps_step.sv */
module sps_step
	import sps_pkg::*;
(
	input  logic [1:0] op,
	input  logic [1:0] mode,
	input  phase_t     phase_cur,
	output phase_t     phase_nxt,
	output logic       moves
);

	phase_t ph_right;
	phase_t ph_left;
	phase_t even_dn;
	phase_t even_up;

	assign even_dn = {phase_cur[2:1], 1'b0};
	assign even_up = {phase_t'(phase_cur + phase_t'(1)) & phase_t'(6)};

	always_comb begin
		case (mode)
			MODE_HALF: begin
				ph_right = phase_cur + phase_t'(1);
				ph_left  = phase_cur - phase_t'(1);
			end
			MODE_FULL_TWO: begin
				ph_right = phase_cur[0] ? phase_cur + phase_t'(2) : phase_t'(1);
				ph_left  = phase_cur[0] ? phase_cur - phase_t'(2) : phase_t'(1);
			end
			default: begin
				ph_right = even_dn + phase_t'(2);
				ph_left  = even_up - phase_t'(2);
			end
		endcase
	end

	always_comb begin
		case (op)
			OP_RIGHT: begin
				phase_nxt = ph_right;
				moves     = 1'b1;
			end
			OP_LEFT: begin
				phase_nxt = ph_left;
				moves     = 1'b1;
			end
			default: begin
				phase_nxt = phase_cur;
				moves     = 1'b0;
			end
		endcase
	end

endmodule

/* src/stepper_phase_sequencer_unit.sv */
// Stepper phase sequencer: one command beat in (op, motor, mode), one result beat out
// (motor_out, coil_pattern). A new command is taken every cycle while the output is not
// stalled; each command passes first the phase memory read, then the phase update, which
// writes back and loads the output register on the same edge. Back-to-back commands to
// the same motor see the phase just written through a forwarding register. Phases read
// as zero after reset through one valid bit per motor; no clearing pass is run.
module stepper_phase_sequencer_unit
	import sps_pkg::*;
#(
	parameter int NUM_MOTORS = NumMotorsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic        motor,
	input  logic [1:0]  mode,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        motor_out,
	output logic [3:0]  coil_pattern
);

	localparam int AddrW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
	localparam int VldN  = 1 << AddrW;

	logic             acc;
	logic             in_rng;
	logic [AddrW-1:0] in_addr;

	logic             valid_s1;
	logic [1:0]       op_s1;
	logic [1:0]       mode_s1;
	logic             motor_s1;
	logic             rng_s1;
	logic [AddrW-1:0] addr_s1;
	logic             adv_s1;

	logic [VldN-1:0]  vld_q;
	logic             fwd_vld_q;
	logic [AddrW-1:0] fwd_addr_q;
	phase_t           fwd_data_q;

	phase_t           rd_phase;
	phase_t           phase_cur;
	phase_t           phase_nxt;
	logic             moves;
	logic             we;

	logic             out_vld_q;
	logic             motor_q;
	coil_t            coil_q;

	assign in_addr = AddrW'(motor);
	assign in_rng  = (32'(motor) < 32'(NUM_MOTORS));
	assign adv_s1  = valid_s1 && (!out_vld_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign acc     = in_valid && in_ready;

	sps_ram #(
		.Width (PhaseW),
		.Depth (NUM_MOTORS)
	) u_phase_ram (
		.clk   (clk),
		.we    (we),
		.waddr (addr_s1),
		.wdata (phase_nxt),
		.re    (acc),
		.raddr (in_addr),
		.rdata (rd_phase)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1    <= op;
			mode_s1  <= mode;
			motor_s1 <= motor;
			rng_s1   <= in_rng;
			addr_s1  <= in_addr;
		end
	end

	// the read issued with a new beat misses a write on the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (acc) begin
			fwd_vld_q <= we;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= phase_nxt;
		end
	end

	always_comb begin
		if (fwd_vld_q && fwd_addr_q == addr_s1) begin
			phase_cur = fwd_data_q;
		end else if (vld_q[addr_s1]) begin
			phase_cur = rd_phase;
		end else begin
			phase_cur = '0;
		end
	end

	sps_step u_step (
		.op        (op_s1),
		.mode      (mode_s1),
		.phase_cur (phase_cur),
		.phase_nxt (phase_nxt),
		.moves     (moves)
	);

	assign we = adv_s1 && moves && rng_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[addr_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			motor_q <= motor_s1;
			coil_q  <= (moves && rng_s1) ? coil_of(phase_nxt) : '0;
		end
	end

	assign out_valid    = out_vld_q;
	assign motor_out    = motor_q;
	assign coil_pattern = coil_q;

	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && !(moves && rng_s1) |=> coil_pattern == '0)
		else $error("coils off beat drove a pattern");

	a_wr_valid: assert property (@(posedge clk) disable iff (!arst_n)
		we |=> vld_q[$past(addr_s1)])
		else $error("written phase entry not marked valid");

	a_two_odd: assert property (@(posedge clk) disable iff (!arst_n)
		we && mode_s1 == MODE_FULL_TWO |-> phase_nxt[0])
		else $error("two winding step left an even phase");

	a_one_even: assert property (@(posedge clk) disable iff (!arst_n)
		we && mode_s1 != MODE_HALF && mode_s1 != MODE_FULL_TWO |-> !phase_nxt[0])
		else $error("one winding step left an odd phase");

	a_coil_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && coil_q != '0 |-> $countones(coil_q) == 1 || $countones(coil_q) == 2)
		else $error("coil pattern drives too many windings");

endmodule
